// ===== rtl/tvc_pkg.sv =====
`default_nettype none

package tvc_pkg;

    // field widths
    localparam int unsigned TempWidth   = 22;
    localparam int unsigned AddrWidth   = 5;
    localparam int unsigned DataWidth   = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] RegSetHigh   = 3'd0;
    localparam logic [2:0] RegSetLow    = 3'd1;
    localparam logic [2:0] RegAlarmHigh = 3'd2;
    localparam logic [2:0] RegAlarmLow  = 3'd3;
    localparam logic [2:0] RegJogHigh   = 3'd4;
    localparam logic [2:0] RegJogLow    = 3'd5;
    localparam logic [2:0] RegValveType = 3'd6;

    // register reset values
    localparam logic signed [TempWidth-1:0] TempResetZero = 22'sd0;
    localparam logic signed [TempWidth-1:0] TempLimitHigh = 22'sd2000000;
    localparam logic signed [TempWidth-1:0] TempLimitLow  = -22'sd2000000;

    // valve types
    localparam logic [7:0] ValveSpring    = 8'h00;
    localparam logic [7:0] ValveSpringAlt = 8'hff;
    localparam logic [7:0] ValveBall      = 8'h01;
    localparam logic [7:0] ValveBallLimit = 8'h02;

    // timer load requests
    localparam logic [1:0] TimerNone = 2'd0;
    localparam logic [1:0] TimerFlip = 2'd1;
    localparam logic [1:0] TimerWait = 2'd2;

    // valve status codes
    localparam logic [2:0] StatusOpen    = 3'd0;
    localparam logic [2:0] StatusOpening = 3'd1;
    localparam logic [2:0] StatusClosing = 3'd2;
    localparam logic [2:0] StatusClosed  = 3'd3;
    localparam logic [2:0] StatusError   = 3'd4;

    // alarm bits
    localparam int unsigned AlarmNoRead = 0;
    localparam int unsigned AlarmHigh   = 1;
    localparam int unsigned AlarmLow    = 2;
    localparam int unsigned AlarmStuck  = 3;

    typedef struct packed {
        logic signed [TempWidth-1:0] temperature;
        logic                        temp_valid;
        logic                        jog_expired;
        logic                        sense_one;
        logic                        sense_two;
    } tvc_sample_t;

    typedef struct packed {
        logic [3:0] alarm_flags;
        logic       drive_open;
        logic       relay_one_set;
        logic       relay_one_reset;
        logic       relay_two_set;
        logic       relay_two_reset;
        logic [1:0] timer_start;
        logic [2:0] valve_status;
    } tvc_result_t;

    typedef struct packed {
        logic signed [TempWidth-1:0] set_high;
        logic signed [TempWidth-1:0] set_low;
        logic signed [TempWidth-1:0] alarm_high;
        logic signed [TempWidth-1:0] alarm_low;
        logic signed [TempWidth-1:0] jog_high;
        logic signed [TempWidth-1:0] jog_low;
        logic [7:0]                  valve_type;
    } tvc_cfg_t;

    typedef struct packed {
        logic       desired_open;
        logic       drive_state;
        logic       jiggle_phase;
        logic       relay_one_on;
        logic       relay_two_on;
        logic [3:0] alarm_state;
    } tvc_state_t;

endpackage

`default_nettype wire

// ===== rtl/tvc_step.sv =====
`default_nettype none

module tvc_step (
    input  wire tvc_pkg::tvc_sample_t sample,
    input  wire tvc_pkg::tvc_cfg_t    cfg,
    input  wire tvc_pkg::tvc_state_t  state,
    output tvc_pkg::tvc_state_t       state_next,
    output tvc_pkg::tvc_result_t      result
);

    logic signed [tvc_pkg::TempWidth-1:0] temp;
    logic spring;
    logic ball;
    logic outside_jog;
    logic drive;
    logic desired;
    logic phase;
    logic [1:0] tstart;
    logic drive_now;
    logic [2:0] status;

    assign temp        = sample.temperature;
    assign spring      = (cfg.valve_type == tvc_pkg::ValveSpring)
                      || (cfg.valve_type == tvc_pkg::ValveSpringAlt);
    assign ball        = (cfg.valve_type == tvc_pkg::ValveBall)
                      || (cfg.valve_type == tvc_pkg::ValveBallLimit);
    assign outside_jog = (temp < cfg.jog_low) || (temp > cfg.jog_high);

    // drive after this request, held when there is no reading
    assign drive_now   = sample.temp_valid ? drive : state.drive_state;

    // hysteresis and jiggle
    always_comb
    begin
        desired = state.desired_open;
        if (temp > cfg.set_high)
        begin
            desired = 1'b1;
        end
        if (temp < cfg.set_low)
        begin
            desired = 1'b0;
        end
        phase  = state.jiggle_phase;
        tstart = tvc_pkg::TimerNone;
        drive  = desired;
        if (outside_jog)
        begin
            if (sample.jog_expired)
            begin
                phase  = ~state.jiggle_phase;
                tstart = phase ? tvc_pkg::TimerFlip : tvc_pkg::TimerWait;
            end
            if (phase)
            begin
                drive = ~desired;
            end
        end
        else if (state.jiggle_phase && sample.jog_expired)
        begin
            phase  = 1'b0;
            tstart = tvc_pkg::TimerWait;
        end
    end

    // state update, relay pulses and alarms
    always_comb
    begin
        state_next             = state;
        result.relay_one_set   = 1'b0;
        result.relay_one_reset = 1'b0;
        result.relay_two_set   = 1'b0;
        result.relay_two_reset = 1'b0;
        result.timer_start     = tvc_pkg::TimerNone;
        if (!sample.temp_valid)
        begin
            state_next.alarm_state[tvc_pkg::AlarmNoRead] = 1'b1;
        end
        else
        begin
            state_next.alarm_state[tvc_pkg::AlarmNoRead] = 1'b0;
            state_next.alarm_state[tvc_pkg::AlarmHigh]   = temp > cfg.alarm_high;
            state_next.alarm_state[tvc_pkg::AlarmLow]    = temp < cfg.alarm_low;
            state_next.alarm_state[tvc_pkg::AlarmStuck]  = outside_jog;
            state_next.desired_open = desired;
            state_next.drive_state  = drive;
            state_next.jiggle_phase = phase;
            result.timer_start      = tstart;
            if (spring)
            begin
                if (drive && !state.relay_one_on)
                begin
                    result.relay_one_set    = 1'b1;
                    state_next.relay_one_on = 1'b1;
                end
                else if (!drive && state.relay_one_on)
                begin
                    result.relay_one_reset  = 1'b1;
                    state_next.relay_one_on = 1'b0;
                end
            end
            else if (ball)
            begin
                if (drive)
                begin
                    result.relay_two_reset  = state.relay_two_on;
                    result.relay_one_set    = ~state.relay_one_on;
                    state_next.relay_two_on = 1'b0;
                    state_next.relay_one_on = 1'b1;
                end
                else
                begin
                    result.relay_one_reset  = state.relay_one_on;
                    result.relay_two_set    = ~state.relay_two_on;
                    state_next.relay_one_on = 1'b0;
                    state_next.relay_two_on = 1'b1;
                end
            end
        end
        result.alarm_flags  = state_next.alarm_state;
        result.drive_open   = state_next.drive_state;
        result.valve_status = status;
    end

    // valve status from the resulting drive and the sensors
    always_comb
    begin
        logic s1;
        logic s2;
        logic d;
        s1 = sample.sense_one;
        s2 = sample.sense_two;
        d  = drive_now;
        if (spring)
        begin
            if (d)
            begin
                status = s1 ? tvc_pkg::StatusOpen : tvc_pkg::StatusOpening;
            end
            else
            begin
                status = s1 ? tvc_pkg::StatusClosing : tvc_pkg::StatusClosed;
            end
        end
        else if (cfg.valve_type == tvc_pkg::ValveBall)
        begin
            status = d ? tvc_pkg::StatusOpen : tvc_pkg::StatusClosed;
        end
        else if (cfg.valve_type == tvc_pkg::ValveBallLimit)
        begin
            if (s1 && s2)
            begin
                status = tvc_pkg::StatusError;
            end
            else if (d)
            begin
                status = (s1 && !s2) ? tvc_pkg::StatusOpen
                                     : tvc_pkg::StatusOpening;
            end
            else
            begin
                status = (s2 && !s1) ? tvc_pkg::StatusClosed
                                     : tvc_pkg::StatusClosing;
            end
        end
        else
        begin
            status = tvc_pkg::StatusError;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/thermostat_valve_controller_unit.sv =====
`default_nettype none

// channel   | handshake                    | payload
// ----------+------------------------------+------------------------------
// sample    | sample_valid / sample_ready  | tvc_sample_t reading request
// result    | result_valid / result_ready  | tvc_result_t one per request
// config    | psel penable pwrite pready   | paddr, pwdata, prdata (APB)
//
// one request per cycle sustained while the result side is ready; a request
// passes the input register, then the step logic into the result register
// the valve and alarm state advance only as a request moves into the
// result register, so a stalled result holds the pipe with no loss
// reset clears the state and valid flags and loads the config reset values at once

module thermostat_valve_controller_unit (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               sample_valid,
    output logic                              sample_ready,
    input  wire tvc_pkg::tvc_sample_t         sample,
    output logic                              result_valid,
    input  wire                               result_ready,
    output tvc_pkg::tvc_result_t              result,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [tvc_pkg::AddrWidth-1:0]      paddr,
    input  wire [tvc_pkg::DataWidth-1:0]      pwdata,
    output logic [tvc_pkg::DataWidth-1:0]     prdata,
    output logic                              pready
);

    tvc_pkg::tvc_cfg_t    cfg_reg;
    tvc_pkg::tvc_state_t  state_reg;
    tvc_pkg::tvc_state_t  state_next;
    tvc_pkg::tvc_sample_t hold_reg;
    logic                 hold_valid_reg;
    tvc_pkg::tvc_result_t result_reg;
    tvc_pkg::tvc_result_t result_next;
    logic                 result_valid_reg;
    logic                 advance;
    logic                 cfg_write;
    logic [2:0]           reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[4:2];

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_high   <= tvc_pkg::TempResetZero;
            cfg_reg.set_low    <= tvc_pkg::TempResetZero;
            cfg_reg.alarm_high <= tvc_pkg::TempLimitHigh;
            cfg_reg.alarm_low  <= tvc_pkg::TempLimitLow;
            cfg_reg.jog_high   <= tvc_pkg::TempLimitHigh;
            cfg_reg.jog_low    <= tvc_pkg::TempLimitLow;
            cfg_reg.valve_type <= tvc_pkg::ValveSpringAlt;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                tvc_pkg::RegSetHigh:   cfg_reg.set_high   <= pwdata[21:0];
                tvc_pkg::RegSetLow:    cfg_reg.set_low    <= pwdata[21:0];
                tvc_pkg::RegAlarmHigh: cfg_reg.alarm_high <= pwdata[21:0];
                tvc_pkg::RegAlarmLow:  cfg_reg.alarm_low  <= pwdata[21:0];
                tvc_pkg::RegJogHigh:   cfg_reg.jog_high   <= pwdata[21:0];
                tvc_pkg::RegJogLow:    cfg_reg.jog_low    <= pwdata[21:0];
                tvc_pkg::RegValveType: cfg_reg.valve_type <= pwdata[7:0];
                default:               ;
            endcase
        end
    end

    // config readback, temperatures sign extended
    always_comb
    begin
        unique case (reg_index)
            tvc_pkg::RegSetHigh:   prdata = 32'($signed(cfg_reg.set_high));
            tvc_pkg::RegSetLow:    prdata = 32'($signed(cfg_reg.set_low));
            tvc_pkg::RegAlarmHigh: prdata = 32'($signed(cfg_reg.alarm_high));
            tvc_pkg::RegAlarmLow:  prdata = 32'($signed(cfg_reg.alarm_low));
            tvc_pkg::RegJogHigh:   prdata = 32'($signed(cfg_reg.jog_high));
            tvc_pkg::RegJogLow:    prdata = 32'($signed(cfg_reg.jog_low));
            tvc_pkg::RegValveType: prdata = {24'd0, cfg_reg.valve_type};
            default:               prdata = '0;
        endcase
    end

    // pipeline flow control
    assign advance      = hold_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !hold_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            hold_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            hold_reg <= sample;
        end
    end

    // step logic
    tvc_step u_step (
        .sample     (hold_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // controller state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg        <= state_next;
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/thermostat_valve_controller_unit_tb.sv =====
`timescale 1ns / 100ps

module thermostat_valve_controller_unit_tb;

    // one directed request, with a hand-worked result where it is obvious
    typedef struct {
        logic                 new_type;
        logic [7:0]           vtype;
        tvc_pkg::tvc_sample_t reading;
        logic                 pinned;
        tvc_pkg::tvc_result_t want;
    } reading_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_ready;
    tvc_pkg::tvc_sample_t          sample;
    logic                          result_valid;
    logic                          result_ready;
    tvc_pkg::tvc_result_t          result;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [tvc_pkg::AddrWidth-1:0] paddr;
    logic [tvc_pkg::DataWidth-1:0] pwdata;
    logic [tvc_pkg::DataWidth-1:0] prdata;
    logic                          pready;

    // predictor copy of the thresholds and valve type
    logic signed [tvc_pkg::TempWidth-1:0] thr_set_high;
    logic signed [tvc_pkg::TempWidth-1:0] thr_set_low;
    logic signed [tvc_pkg::TempWidth-1:0] thr_alarm_high;
    logic signed [tvc_pkg::TempWidth-1:0] thr_alarm_low;
    logic signed [tvc_pkg::TempWidth-1:0] thr_jog_high;
    logic signed [tvc_pkg::TempWidth-1:0] thr_jog_low;
    logic [7:0]                           valve_kind;

    // predictor copy of the valve and alarm state
    tvc_pkg::tvc_state_t plant;

    tvc_pkg::tvc_result_t expected_results[$];
    reading_row_t         directed_rows[$];
    int                   mismatches;
    bit                   gaps_on;

    thermostat_valve_controller_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        result_ready = gaps_on ? ($urandom_range(0, 99) >= 16) : 1'b1;
    end

    // hysteresis, alarms, jiggle and relay pulses for one request
    function automatic tvc_pkg::tvc_result_t predict_reading(tvc_pkg::tvc_sample_t s);
        logic signed [tvc_pkg::TempWidth-1:0] t;
        tvc_pkg::tvc_result_t                 r;
        t = s.temperature;
        r = '0;
        if (!s.temp_valid)
        begin
            plant.alarm_state[tvc_pkg::AlarmNoRead] = 1'b1;
        end
        else
        begin
            plant.alarm_state[tvc_pkg::AlarmNoRead] = 1'b0;
            plant.alarm_state[tvc_pkg::AlarmHigh]   = (t > thr_alarm_high);
            plant.alarm_state[tvc_pkg::AlarmLow]    = (t < thr_alarm_low);
            if (t > thr_set_high)
                plant.desired_open = 1'b1;
            if (t < thr_set_low)
                plant.desired_open = 1'b0;
            plant.drive_state = plant.desired_open;

            // outside the jog window the valve counts as stuck
            if (t < thr_jog_low || t > thr_jog_high)
            begin
                plant.alarm_state[tvc_pkg::AlarmStuck] = 1'b1;
                if (s.jog_expired)
                begin
                    plant.jiggle_phase = ~plant.jiggle_phase;
                    r.timer_start = plant.jiggle_phase ? tvc_pkg::TimerFlip
                                                       : tvc_pkg::TimerWait;
                end
                if (plant.jiggle_phase)
                    plant.drive_state = ~plant.drive_state;
            end
            else
            begin
                plant.alarm_state[tvc_pkg::AlarmStuck] = 1'b0;
                if (plant.jiggle_phase && s.jog_expired)
                begin
                    plant.jiggle_phase = 1'b0;
                    r.timer_start = tvc_pkg::TimerWait;
                end
            end

            // relay pulses by valve type
            if (valve_kind == tvc_pkg::ValveSpring || valve_kind == tvc_pkg::ValveSpringAlt)
            begin
                if (plant.drive_state && !plant.relay_one_on)
                begin
                    r.relay_one_set = 1'b1;
                    plant.relay_one_on = 1'b1;
                end
                else if (!plant.drive_state && plant.relay_one_on)
                begin
                    r.relay_one_reset = 1'b1;
                    plant.relay_one_on = 1'b0;
                end
            end
            else if (valve_kind == tvc_pkg::ValveBall
                  || valve_kind == tvc_pkg::ValveBallLimit)
            begin
                if (plant.drive_state)
                begin
                    if (plant.relay_two_on)
                    begin
                        r.relay_two_reset = 1'b1;
                        plant.relay_two_on = 1'b0;
                    end
                    if (!plant.relay_one_on)
                    begin
                        r.relay_one_set = 1'b1;
                        plant.relay_one_on = 1'b1;
                    end
                end
                else
                begin
                    if (plant.relay_one_on)
                    begin
                        r.relay_one_reset = 1'b1;
                        plant.relay_one_on = 1'b0;
                    end
                    if (!plant.relay_two_on)
                    begin
                        r.relay_two_set = 1'b1;
                        plant.relay_two_on = 1'b1;
                    end
                end
            end
        end

        // status from drive and sensors
        if (valve_kind == tvc_pkg::ValveSpring || valve_kind == tvc_pkg::ValveSpringAlt)
        begin
            if (plant.drive_state)
                r.valve_status = s.sense_one ? tvc_pkg::StatusOpen : tvc_pkg::StatusOpening;
            else
                r.valve_status = s.sense_one ? tvc_pkg::StatusClosing : tvc_pkg::StatusClosed;
        end
        else if (valve_kind == tvc_pkg::ValveBall)
        begin
            r.valve_status = plant.drive_state ? tvc_pkg::StatusOpen : tvc_pkg::StatusClosed;
        end
        else if (valve_kind == tvc_pkg::ValveBallLimit)
        begin
            if (s.sense_one && s.sense_two)
                r.valve_status = tvc_pkg::StatusError;
            else if (plant.drive_state)
                r.valve_status = (s.sense_one && !s.sense_two) ? tvc_pkg::StatusOpen
                                                               : tvc_pkg::StatusOpening;
            else
                r.valve_status = (s.sense_two && !s.sense_one) ? tvc_pkg::StatusClosed
                                                               : tvc_pkg::StatusClosing;
        end
        else
        begin
            r.valve_status = tvc_pkg::StatusError;
        end

        r.alarm_flags = plant.alarm_state;
        r.drive_open  = plant.drive_state;
        return r;
    endfunction

    function automatic reading_row_t reading_row(logic chg, logic [7:0] vt, int temp,
                                                 logic valid, logic expd, logic s1, logic s2,
                                                 logic pin, tvc_pkg::tvc_result_t want);
        reading_row_t row;
        row.new_type            = chg;
        row.vtype               = vt;
        row.reading.temperature = temp[tvc_pkg::TempWidth-1:0];
        row.reading.temp_valid  = valid;
        row.reading.jog_expired = expd;
        row.reading.sense_one   = s1;
        row.reading.sense_two   = s2;
        row.pinned              = pin;
        row.want                = want;
        return row;
    endfunction

    // random request, mostly close to one of the active thresholds
    function automatic tvc_pkg::tvc_sample_t random_reading();
        tvc_pkg::tvc_sample_t s;
        int                   t;
        int                   base;
        case ($urandom_range(0, 5))
            0: base = thr_set_high;
            1: base = thr_set_low;
            2: base = thr_alarm_high;
            3: base = thr_alarm_low;
            4: base = thr_jog_high;
            default: base = thr_jog_low;
        endcase
        case ($urandom_range(0, 9))
            0: t = $urandom;
            1: t = $urandom_range(0, 1) ? 2097151 : -2097152;
            2, 3: t = base + int'($urandom_range(0, 4000)) - 2000;
            default: t = base + int'($urandom_range(0, 6)) - 3;
        endcase
        s.temperature = t[tvc_pkg::TempWidth-1:0];
        s.temp_valid  = ($urandom_range(0, 99) < 88);
        s.jog_expired = ($urandom_range(0, 2) == 0);
        s.sense_one   = 1'($urandom_range(0, 1));
        s.sense_two   = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(tvc_pkg::tvc_result_t want, tvc_pkg::tvc_result_t got);
        compare_field("alarm_flags", want.alarm_flags, got.alarm_flags);
        compare_field("drive_open", want.drive_open, got.drive_open);
        compare_field("relay_one_set", want.relay_one_set, got.relay_one_set);
        compare_field("relay_one_reset", want.relay_one_reset, got.relay_one_reset);
        compare_field("relay_two_set", want.relay_two_set, got.relay_two_set);
        compare_field("relay_two_reset", want.relay_two_reset, got.relay_two_reset);
        compare_field("timer_start", want.timer_start, got.timer_start);
        compare_field("valve_status", want.valve_status, got.valve_status);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no pending request: expected none, got %p",
                         $time, result);
                mismatches++;
            end
            else
            begin
                check_result(expected_results.pop_front(), result);
            end
        end
    end

    // present one request, called and returning at a falling edge
    task automatic send_reading(tvc_pkg::tvc_sample_t s, bit pinned,
                                tvc_pkg::tvc_result_t want);
        tvc_pkg::tvc_result_t predicted;
        while (gaps_on && $urandom_range(0, 99) < 16)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample       = s;
        sample_valid = 1'b1;
        do @(posedge clk); while (!sample_ready);
        predicted = predict_reading(s);
        expected_results.push_back(pinned ? want : predicted);
        @(negedge clk);
    endtask

    // drain the pipe so the block is idle
    task automatic wait_idle();
        sample_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            tvc_pkg::RegSetHigh:   thr_set_high   = data[tvc_pkg::TempWidth-1:0];
            tvc_pkg::RegSetLow:    thr_set_low    = data[tvc_pkg::TempWidth-1:0];
            tvc_pkg::RegAlarmHigh: thr_alarm_high = data[tvc_pkg::TempWidth-1:0];
            tvc_pkg::RegAlarmLow:  thr_alarm_low  = data[tvc_pkg::TempWidth-1:0];
            tvc_pkg::RegJogHigh:   thr_jog_high   = data[tvc_pkg::TempWidth-1:0];
            tvc_pkg::RegJogLow:    thr_jog_low    = data[tvc_pkg::TempWidth-1:0];
            tvc_pkg::RegValveType: valve_kind     = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(int sh, int sl, int ah, int al, int jh, int jl, logic [7:0] vt);
        wait_idle();
        write_reg(tvc_pkg::RegSetHigh, sh);
        write_reg(tvc_pkg::RegSetLow, sl);
        write_reg(tvc_pkg::RegAlarmHigh, ah);
        write_reg(tvc_pkg::RegAlarmLow, al);
        write_reg(tvc_pkg::RegJogHigh, jh);
        write_reg(tvc_pkg::RegJogLow, jl);
        write_reg(tvc_pkg::RegValveType, vt);
    endtask

    // run limit
    initial
    begin
        #5_000_000;
        $display("** thermostat_valve_controller_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int                   c;
        int                   h;
        int                   j;
        int                   a;
        logic [7:0]           vt;
        tvc_pkg::tvc_result_t none;

        clk          = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        result_ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        gaps_on      = 1'b1;
        none         = '0;

        thr_set_high   = tvc_pkg::TempResetZero;
        thr_set_low    = tvc_pkg::TempResetZero;
        thr_alarm_high = tvc_pkg::TempLimitHigh;
        thr_alarm_low  = tvc_pkg::TempLimitLow;
        thr_jog_high   = tvc_pkg::TempLimitHigh;
        thr_jog_low    = tvc_pkg::TempLimitLow;
        valve_kind     = tvc_pkg::ValveSpringAlt;
        plant          = '0;

        // directed requests under reset thresholds, then each valve type
        directed_rows.push_back(reading_row(0, 0, 0, 0, 0, 0, 0, 1,
            '{4'h1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, tvc_pkg::TimerNone,
              tvc_pkg::StatusClosed}));
        directed_rows.push_back(reading_row(0, 0, 2000000, 1, 0, 1, 0, 1,
            '{4'h0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, tvc_pkg::TimerNone,
              tvc_pkg::StatusOpen}));
        directed_rows.push_back(reading_row(0, 0, -2000000, 1, 0, 0, 0, 1,
            '{4'h0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, tvc_pkg::TimerNone,
              tvc_pkg::StatusClosed}));
        directed_rows.push_back(reading_row(0, 0, 2097151, 1, 1, 0, 1, 1,
            '{4'ha, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, tvc_pkg::TimerFlip,
              tvc_pkg::StatusClosed}));
        directed_rows.push_back(reading_row(0, 0, -2097152, 1, 1, 0, 0, 1,
            '{4'hc, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, tvc_pkg::TimerWait,
              tvc_pkg::StatusClosed}));
        directed_rows.push_back(reading_row(0, 0, 0, 1, 1, 1, 1, 0, none));
        directed_rows.push_back(reading_row(0, 0, 2097151, 1, 1, 1, 0, 0, none));
        directed_rows.push_back(reading_row(0, 0, 0, 1, 0, 0, 1, 0, none));
        directed_rows.push_back(reading_row(0, 0, 0, 1, 1, 1, 0, 0, none));
        directed_rows.push_back(reading_row(0, 0, 2097151, 0, 1, 1, 1, 0, none));
        directed_rows.push_back(reading_row(0, 0, -1, 1, 0, 0, 0, 0, none));
        directed_rows.push_back(reading_row(1, tvc_pkg::ValveBall, 100, 1, 0, 0, 0, 0, none));
        directed_rows.push_back(reading_row(0, 0, -100, 1, 0, 1, 1, 0, none));
        directed_rows.push_back(reading_row(1, tvc_pkg::ValveBallLimit, 100, 1, 0, 1, 1, 0,
                                            none));
        directed_rows.push_back(reading_row(0, 0, 100, 1, 0, 1, 0, 0, none));
        directed_rows.push_back(reading_row(0, 0, 100, 1, 0, 0, 0, 0, none));
        directed_rows.push_back(reading_row(0, 0, -100, 1, 0, 0, 1, 0, none));
        directed_rows.push_back(reading_row(0, 0, -100, 1, 0, 0, 0, 0, none));
        directed_rows.push_back(reading_row(1, 8'd7, 100, 1, 0, 1, 0, 0, none));
        directed_rows.push_back(reading_row(1, tvc_pkg::ValveSpring, 100, 1, 0, 0, 0, 0,
                                            none));
        directed_rows.push_back(reading_row(0, 0, -100, 1, 0, 1, 0, 0, none));
        directed_rows.push_back(reading_row(0, 0, -100, 0, 0, 0, 1, 0, none));

        // hold reset, then release it at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].new_type)
            begin
                wait_idle();
                write_reg(tvc_pkg::RegValveType, directed_rows[i].vtype);
            end
            send_reading(directed_rows[i].reading, directed_rows[i].pinned,
                         directed_rows[i].want);
        end

        // random phases, each under its own thresholds
        for (int phase = 0; phase < 7; phase++)
        begin
            c  = int'($urandom_range(0, 3000000)) - 1500000;
            h  = $urandom_range(1, 20000);
            j  = h + int'($urandom_range(0, 50000));
            a  = $urandom_range(0, 100000);
            case (phase)
                0: vt = tvc_pkg::ValveSpringAlt;
                1: vt = tvc_pkg::ValveBall;
                2: vt = tvc_pkg::ValveBallLimit;
                3: vt = tvc_pkg::ValveSpring;
                4: vt = 8'($urandom_range(3, 254));
                5: vt = tvc_pkg::ValveBallLimit;
                default: vt = tvc_pkg::ValveBall;
            endcase
            case (phase)
                0: set_config(tvc_pkg::TempResetZero, tvc_pkg::TempResetZero,
                              tvc_pkg::TempLimitHigh, tvc_pkg::TempLimitLow,
                              tvc_pkg::TempLimitHigh, tvc_pkg::TempLimitLow, vt);
                // inverted extremes: always stuck, at least one alarm always on
                1: set_config(2097151, -2097152, -2097152, 2097151, -2097152, 2097151, vt);
                // set points crossed over
                5: set_config(c - h, c + h, c + j + a, c - j - a, c + j, c - j, vt);
                default: set_config(c + h, c - h, c + j + a, c - j - a, c + j, c - j, vt);
            endcase
            // one phase runs with no idling on either side
            gaps_on = (phase != 2);
            for (int n = 0; n < 100; n++)
                send_reading(random_reading(), 1'b0, none);
        end

        wait_idle();
        if (mismatches == 0)
            $display("** thermostat_valve_controller_unit: PASSED **");
        else
            $display("** thermostat_valve_controller_unit: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tvc_pkg.sv
rtl/tvc_step.sv
rtl/thermostat_valve_controller_unit.sv
tb/sv/thermostat_valve_controller_unit_tb.sv
